/* sv/tpf_pkg.sv */
// shared constants, types and crc helper for the telemetry packet framer
package tpf_pkg;

	localparam int unsigned MAX_SENSORS_DEF = 1024;

	// field widths
	localparam int unsigned IDX_W = 10;
	localparam int unsigned TS_W  = 64;
	localparam int unsigned RD_W  = 32;
	localparam int unsigned ID_W  = 16;
	localparam int unsigned SEQ_W = 32;
	localparam int unsigned BYTE_W = 8;

	// input tdata layout, lowest bit first
	localparam int unsigned IDX_LSB   = 0;
	localparam int unsigned FAULT_LSB = IDX_LSB + IDX_W;
	localparam int unsigned TS_LSB    = FAULT_LSB + 1;
	localparam int unsigned VOLT_LSB  = TS_LSB + TS_W;
	localparam int unsigned CURR_LSB  = VOLT_LSB + RD_W;
	localparam int unsigned FREQ_LSB  = CURR_LSB + RD_W;
	localparam int unsigned S_FIELDS_W = FREQ_LSB + RD_W;
	localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;

	// frame constants
	localparam logic [15:0] MAGIC_WORD   = 16'h4750;
	localparam logic [7:0]  VERSION_BYTE = 8'h01;
	localparam logic [15:0] CRC_INIT     = 16'hFFFF;
	localparam logic [15:0] CRC_POLY     = 16'h1021;
	localparam logic [ID_W-1:0] ID_BASE_RST = 16'd100;
	localparam int unsigned FRAME_LEN  = 32;
	localparam int unsigned CRC_SPAN   = 30;
	localparam int unsigned BCNT_W     = 5;
	localparam int unsigned HDR_W      = CRC_SPAN * BYTE_W;
	localparam logic [BCNT_W-1:0] CRC_HI_IDX = BCNT_W'(CRC_SPAN);
	localparam logic [BCNT_W-1:0] LAST_IDX   = BCNT_W'(FRAME_LEN - 1);

	// slot reduction by reciprocal multiply
	localparam int unsigned RECIP_SHIFT = 20;
	localparam int unsigned RECIP_W     = RECIP_SHIFT + 1;
	localparam int unsigned PROD_W      = IDX_W + RECIP_W;
	localparam int unsigned REM_W       = IDX_W + 17;

	// queue between front and back
	localparam int unsigned QUEUE_DEPTH = 4;
	localparam int unsigned QPTR_W      = 2;
	localparam int unsigned QCNT_W      = 3;
	localparam int unsigned OCC_W       = QCNT_W + 1;

	typedef struct packed {
		logic [ID_W-1:0]  dev_id;
		logic             fault;
		logic [SEQ_W-1:0] seq;
		logic [TS_W-1:0]  timestamp;
		logic [RD_W-1:0]  voltage;
		logic [RD_W-1:0]  current;
		logic [RD_W-1:0]  freq;
	} frame_t;

	typedef struct packed {
		logic              empty;
		logic [QCNT_W-1:0] count;
	} queue_status_t;

	// one byte through the msb-first crc-16 register
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
			input logic [BYTE_W-1:0] data);
		logic [15:0] c;
		c = crc_in ^ {data, 8'h00};
		for (int b = 0; b < 8; b++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

/* sv/tpf_ram.sv */
// generic single-port-write, registered-read ram
module tpf_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 1024,
	parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// read returns the old word on a same-address write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* sv/tpf_front.sv */
// front end: input transfer, slot reduction, sequence counter update, reset clear pass
module tpf_front #(
	parameter int unsigned MAX_SENSORS = tpf_pkg::MAX_SENSORS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [tpf_pkg::S_TDATA_W-1:0]  s_tdata,
	input  logic                           cfg_wr_en,
	input  logic [tpf_pkg::ID_W-1:0]       cfg_wr_data,
	input  tpf_pkg::queue_status_t         q_status,
	output logic                           push,
	output tpf_pkg::frame_t                push_entry,
	output logic                           clearing
);

	localparam int unsigned ADDR_W = (MAX_SENSORS > 1) ? $clog2(MAX_SENSORS) : 1;
	localparam int unsigned RECIP =
		((1 << tpf_pkg::RECIP_SHIFT) + MAX_SENSORS - 1) / MAX_SENSORS;
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MAX_SENSORS - 1);
	localparam logic [tpf_pkg::REM_W-1:0] MOD = tpf_pkg::REM_W'(MAX_SENSORS);

	logic                          clr_q;
	logic [ADDR_W-1:0]             clr_addr_q;
	logic [tpf_pkg::ID_W-1:0]      id_base_q;

	logic                          valid_s1;
	logic [tpf_pkg::IDX_W-1:0]     idx_s1;
	logic [tpf_pkg::IDX_W-1:0]     quot_s1;
	logic                          fault_s1;
	logic [tpf_pkg::TS_W-1:0]      ts_s1;
	logic [tpf_pkg::RD_W-1:0]      volt_s1;
	logic [tpf_pkg::RD_W-1:0]      curr_s1;
	logic [tpf_pkg::RD_W-1:0]      freq_s1;

	logic                          valid_s2;
	logic [ADDR_W-1:0]             slot_s2;
	logic [tpf_pkg::ID_W-1:0]      id_s2;
	logic                          fault_s2;
	logic [tpf_pkg::TS_W-1:0]      ts_s2;
	logic [tpf_pkg::RD_W-1:0]      volt_s2;
	logic [tpf_pkg::RD_W-1:0]      curr_s2;
	logic [tpf_pkg::RD_W-1:0]      freq_s2;
	logic                          fwd_s2;
	logic [tpf_pkg::SEQ_W-1:0]     fwd_seq_s2;

	logic                          s_xfer;
	logic                          adv_s1;
	logic [tpf_pkg::OCC_W-1:0]     occ;
	logic [tpf_pkg::IDX_W-1:0]     in_idx;
	logic [tpf_pkg::PROD_W-1:0]    prod;
	logic [tpf_pkg::REM_W-1:0]     quot_m;
	logic [tpf_pkg::REM_W-1:0]     rem_raw;
	logic [tpf_pkg::REM_W-1:0]     rem_fix;
	logic [ADDR_W-1:0]             slot_s1;
	logic [tpf_pkg::SEQ_W-1:0]     rd_seq;
	logic [tpf_pkg::SEQ_W-1:0]     seq_cur;
	logic [tpf_pkg::SEQ_W-1:0]     seq_nxt;
	logic                          ram_we;
	logic [ADDR_W-1:0]             ram_waddr;
	logic [tpf_pkg::SEQ_W-1:0]     ram_wdata;

	assign in_idx = s_tdata[tpf_pkg::IDX_LSB +: tpf_pkg::IDX_W];

	// quotient estimate, exact for 10-bit indexes
	assign prod = tpf_pkg::PROD_W'(in_idx) * tpf_pkg::PROD_W'(RECIP);

	always_comb begin
		quot_m  = tpf_pkg::REM_W'(quot_s1) * MOD;
		rem_raw = tpf_pkg::REM_W'(idx_s1) - quot_m;
		rem_fix = (rem_raw >= MOD) ? (rem_raw - MOD) : rem_raw;
		slot_s1 = rem_fix[ADDR_W-1:0];
	end

	// the slot in stage 2 reaches the ram in the cycle after stage 1 read it
	assign seq_cur = fwd_s2 ? fwd_seq_s2 : rd_seq;
	assign seq_nxt = seq_cur + tpf_pkg::SEQ_W'(1);

	assign occ    = tpf_pkg::OCC_W'(q_status.count) + tpf_pkg::OCC_W'(valid_s2);
	assign adv_s1 = valid_s1 && (occ < tpf_pkg::OCC_W'(tpf_pkg::QUEUE_DEPTH));
	assign s_tready = !clr_q && (!valid_s1 || adv_s1);
	assign s_xfer = s_tvalid && s_tready;
	assign clearing = clr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q      <= 1'b1;
			clr_addr_q <= '0;
			id_base_q  <= tpf_pkg::ID_BASE_RST;
			valid_s1   <= 1'b0;
			valid_s2   <= 1'b0;
		end else begin
			if (clr_q) begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
				if (clr_addr_q == LAST_ADDR) begin
					clr_q <= 1'b0;
				end
			end
			if (cfg_wr_en) begin
				id_base_q <= cfg_wr_data;
			end
			if (s_xfer) begin
				valid_s1 <= 1'b1;
			end else if (adv_s1) begin
				valid_s1 <= 1'b0;
			end
			valid_s2 <= adv_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s_xfer) begin
			idx_s1   <= in_idx;
			quot_s1  <= prod[tpf_pkg::RECIP_SHIFT +: tpf_pkg::IDX_W];
			fault_s1 <= s_tdata[tpf_pkg::FAULT_LSB];
			ts_s1    <= s_tdata[tpf_pkg::TS_LSB +: tpf_pkg::TS_W];
			volt_s1  <= s_tdata[tpf_pkg::VOLT_LSB +: tpf_pkg::RD_W];
			curr_s1  <= s_tdata[tpf_pkg::CURR_LSB +: tpf_pkg::RD_W];
			freq_s1  <= s_tdata[tpf_pkg::FREQ_LSB +: tpf_pkg::RD_W];
		end
		if (adv_s1) begin
			slot_s2    <= slot_s1;
			id_s2      <= id_base_q + tpf_pkg::ID_W'(idx_s1);
			fault_s2   <= fault_s1;
			ts_s2      <= ts_s1;
			volt_s2    <= volt_s1;
			curr_s2    <= curr_s1;
			freq_s2    <= freq_s1;
			fwd_s2     <= valid_s2 && (slot_s2 == slot_s1);
			fwd_seq_s2 <= seq_nxt;
		end
	end

	always_comb begin
		ram_we    = clr_q || valid_s2;
		ram_waddr = clr_q ? clr_addr_q : slot_s2;
		ram_wdata = clr_q ? '0 : seq_nxt;
	end

	tpf_ram #(
		.WIDTH (tpf_pkg::SEQ_W),
		.DEPTH (MAX_SENSORS),
		.ADDR_W(ADDR_W)
	) u_seq_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(slot_s1),
		.rdata(rd_seq)
	);

	always_comb begin
		push                 = valid_s2;
		push_entry.dev_id    = id_s2;
		push_entry.fault     = fault_s2;
		push_entry.seq       = seq_cur;
		push_entry.timestamp = ts_s2;
		push_entry.voltage   = volt_s2;
		push_entry.current   = curr_s2;
		push_entry.freq      = freq_s2;
	end

endmodule

/* sv/tpf_queue.sv */
// short frame queue between front and back
module tpf_queue (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   push,
	input  tpf_pkg::frame_t        push_entry,
	input  logic                   pop,
	output tpf_pkg::frame_t        head,
	output tpf_pkg::queue_status_t status
);

	tpf_pkg::frame_t                mem_q [tpf_pkg::QUEUE_DEPTH];
	logic [tpf_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [tpf_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [tpf_pkg::QCNT_W-1:0]     count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + tpf_pkg::QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + tpf_pkg::QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + tpf_pkg::QCNT_W'(1);
			end else if (pop && !push) begin
				count_q <= count_q - tpf_pkg::QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	assign head = mem_q[rd_ptr_q];

	always_comb begin
		status.empty = (count_q == '0);
		status.count = count_q;
	end

endmodule

/* sv/tpf_back.sv */
// back end: frame serializer with running crc and output register
module tpf_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  tpf_pkg::queue_status_t      q_status,
	input  tpf_pkg::frame_t             head,
	output logic                        pop,
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [tpf_pkg::BYTE_W-1:0]  m_tdata,
	output logic                        m_tlast
);

	logic                          busy_q;
	logic [tpf_pkg::BCNT_W-1:0]    cnt_q;
	logic [tpf_pkg::HDR_W-1:0]     sr_q;
	logic [15:0]                   crc_q;
	logic                          m_tvalid_q;
	logic [tpf_pkg::BYTE_W-1:0]    m_tdata_q;
	logic                          m_tlast_q;

	logic                          load;
	logic                          in_span;
	logic [tpf_pkg::BYTE_W-1:0]    cur_byte;
	logic [tpf_pkg::HDR_W-1:0]     hdr;

	assign load    = busy_q && (!m_tvalid_q || m_tready);
	assign in_span = (cnt_q < tpf_pkg::CRC_HI_IDX);
	// next frame is popped in the cycle its predecessor's last byte is loaded into the output register
	assign pop = !q_status.empty && (!busy_q || (load && (cnt_q == tpf_pkg::LAST_IDX)));

	always_comb begin
		if (in_span) begin
			cur_byte = sr_q[tpf_pkg::HDR_W-1 -: tpf_pkg::BYTE_W];
		end else if (cnt_q == tpf_pkg::CRC_HI_IDX) begin
			cur_byte = crc_q[15:8];
		end else begin
			cur_byte = crc_q[7:0];
		end
	end

	assign hdr = {tpf_pkg::MAGIC_WORD, tpf_pkg::VERSION_BYTE, 7'b0, head.fault,
		head.dev_id, head.seq, head.timestamp, head.voltage, head.current,
		head.freq};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b0;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (load) begin
				cnt_q <= cnt_q + tpf_pkg::BCNT_W'(1);
				if (cnt_q == tpf_pkg::LAST_IDX) begin
					busy_q <= 1'b0;
				end
			end
			if (load) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sr_q  <= hdr;
			crc_q <= tpf_pkg::CRC_INIT;
		end else if (load && in_span) begin
			sr_q  <= {sr_q[tpf_pkg::HDR_W-tpf_pkg::BYTE_W-1:0], tpf_pkg::BYTE_W'(0)};
			crc_q <= tpf_pkg::crc_byte(crc_q, cur_byte);
		end
		if (load) begin
			m_tdata_q <= cur_byte;
			m_tlast_q <= (cnt_q == tpf_pkg::LAST_IDX);
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

/* sv/telemetry_packet_framer.sv */
// top level of the telemetry packet framer
//
//  port group   dir  payload                                   transfer
//  s_*          in   one sensor reading set (tdata, 176 bits)  s_tvalid & s_tready
//  m_*          out  one frame byte, tlast on byte 31          m_tvalid & m_tready
//  cfg_*        in   id_base, 16 bits                          cfg_wr_en
//
//  each reading set becomes a 32-byte frame sent one byte per cycle unless the
//  receiver holds m_tready low
//  idle path to the first byte: stage 1, stage 2, queue, shift register, output register
//  after reset a clear pass over every slot zeroes the counters; s_tready stays low
//  a stalled output fills a 4-frame queue, then the front end stops taking input
module telemetry_packet_framer #(
	parameter int unsigned MAX_SENSORS = tpf_pkg::MAX_SENSORS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           s_tvalid,
	output logic                           s_tready,
	// sensor_index, fault_active, time in ms, voltage, current, frequency
	input  logic [tpf_pkg::S_TDATA_W-1:0]  s_tdata,
	output logic                           m_tvalid,
	input  logic                           m_tready,
	// out_byte
	output logic [tpf_pkg::BYTE_W-1:0]     m_tdata,
	output logic                           m_tlast,
	input  logic                           cfg_wr_en,
	input  logic [tpf_pkg::ID_W-1:0]       cfg_wr_data
);

	tpf_pkg::frame_t        push_entry;
	tpf_pkg::frame_t        head;
	tpf_pkg::queue_status_t q_status;
	logic                   push;
	logic                   pop;
	logic                   clearing;

	tpf_front #(
		.MAX_SENSORS(MAX_SENSORS)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.q_status   (q_status),
		.push       (push),
		.push_entry (push_entry),
		.clearing   (clearing)
	);

	tpf_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_entry(push_entry),
		.pop       (pop),
		.head      (head),
		.status    (q_status)
	);

	tpf_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_status(q_status),
		.head    (head),
		.pop     (pop),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

	a_clear_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !s_tready)
		else $error("input taken during counter clear");

	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_status.count < tpf_pkg::QCNT_W'(tpf_pkg::QUEUE_DEPTH)))
		else $error("frame queue overflow");

	a_queue_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !q_status.empty)
		else $error("frame queue underflow");

	a_last_ends_frame: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> !(m_tvalid && m_tlast))
		else $error("two last bytes in a row");

endmodule

/* verif/tb_telemetry_packet_framer.sv */
// self-checking testbench for the telemetry packet framer
module tb_telemetry_packet_framer;

	localparam int unsigned CYCLE_LIMIT = 400000;
	localparam int unsigned DRAIN_CYCLES = 12;
	localparam int unsigned RAND_PER_PHASE = 48;
	localparam int unsigned HOLD_CYCLES = 700;
	localparam int unsigned HOLD_ITEMS = 12;
	localparam int unsigned N_DIR = 15;

	typedef struct packed {
		logic [tpf_pkg::IDX_W-1:0] idx;
		logic                      fault;
		logic [tpf_pkg::TS_W-1:0]  ts;
		logic [tpf_pkg::RD_W-1:0]  volt;
		logic [tpf_pkg::RD_W-1:0]  curr;
		logic [tpf_pkg::RD_W-1:0]  freq;
	} reading_t;

	// directed row: optional id_base write before the item, typed id and sequence
	typedef struct packed {
		logic                      wr_cfg;
		logic [tpf_pkg::ID_W-1:0]  cfg_val;
		reading_t                  rd;
		logic                      known;
		logic [tpf_pkg::ID_W-1:0]  id;
		logic [tpf_pkg::SEQ_W-1:0] seq;
	} dir_row_t;

	typedef struct packed {
		logic [tpf_pkg::BYTE_W-1:0] data;
		logic                       last;
	} frame_byte_t;

	localparam logic [63:0] TS_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [31:0] RD_MAX = 32'hFFFF_FFFF;

	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{1'b0, 16'd0, '{10'd0, 1'b0, 64'd0, 32'd0, 32'd0, 32'd0}, 1'b1, 16'd100, 32'd0},
		'{1'b0, 16'd0, '{10'd0, 1'b1, TS_MAX, RD_MAX, RD_MAX, RD_MAX}, 1'b1, 16'd100, 32'd1},
		'{1'b0, 16'd0, '{10'd1023, 1'b0, TS_MAX, 32'd0, RD_MAX, 32'd0}, 1'b1, 16'd1123, 32'd0},
		'{1'b0, 16'd0, '{10'd1023, 1'b1, 64'd0, RD_MAX, 32'd0, RD_MAX}, 1'b1, 16'd1123, 32'd1},
		'{1'b0, 16'd0, '{10'd5, 1'b0, 64'h0123_4567_89AB_CDEF, 32'd230000, 32'd15000,
			32'd50000}, 1'b1, 16'd105, 32'd0},
		'{1'b0, 16'd0, '{10'd5, 1'b1, 64'h8000_0000_0000_0001, 32'h8000_0001,
			32'h7FFF_FFFE, 32'h0000_FFFF}, 1'b1, 16'd105, 32'd1},
		// id wraps past 16 bits
		'{1'b1, 16'hFFFF, '{10'd1, 1'b0, 64'd1, 32'd1, 32'd1, 32'd1}, 1'b1, 16'd0, 32'd0},
		'{1'b0, 16'd0, '{10'd1023, 1'b0, 64'd2, 32'd2, 32'd2, 32'd2}, 1'b1, 16'd1022, 32'd2},
		'{1'b0, 16'd0, '{10'd0, 1'b1, 64'd3, 32'd3, 32'd3, 32'd3}, 1'b1, 16'hFFFF, 32'd2},
		'{1'b1, 16'h0000, '{10'd0, 1'b0, 64'd4, 32'd4, 32'd4, 32'd4}, 1'b1, 16'd0, 32'd3},
		'{1'b0, 16'd0, '{10'd512, 1'b0, 64'd5, 32'd5, 32'd5, 32'd5}, 1'b1, 16'd512, 32'd0},
		'{1'b0, 16'd0, '{10'd682, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_5555,
			32'hAAAA_AAAA, 32'h5555_5555}, 1'b1, 16'd682, 32'd0},
		'{1'b0, 16'd0, '{10'd341, 1'b0, 64'h5555_5555_5555_5555, 32'hAAAA_AAAA,
			32'h5555_5555, 32'hAAAA_AAAA}, 1'b1, 16'd341, 32'd0},
		'{1'b1, 16'hFC00, '{10'd1023, 1'b1, 64'd6, 32'd6, 32'd6, 32'd6}, 1'b1, 16'hFFFF, 32'd3},
		'{1'b0, 16'd0, '{10'd1, 1'b0, 64'd7, 32'd7, 32'd7, 32'd7}, 1'b1, 16'hFC01, 32'd1}
	};

	logic                          clk;
	logic                          arst_n;
	logic                          s_tvalid;
	logic                          s_tready;
	logic [tpf_pkg::S_TDATA_W-1:0] s_tdata;
	logic                          m_tvalid;
	logic                          m_tready;
	logic [tpf_pkg::BYTE_W-1:0]    m_tdata;
	logic                          m_tlast;
	logic                          cfg_wr_en;
	logic [tpf_pkg::ID_W-1:0]      cfg_wr_data;

	// predictor state
	logic [tpf_pkg::SEQ_W-1:0] slot_seq [tpf_pkg::MAX_SENSORS_DEF];
	logic [tpf_pkg::ID_W-1:0]  id_base_model;
	frame_byte_t               pending_bytes [$];
	frame_byte_t               want;

	int unsigned cycles;
	int unsigned errors;
	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	logic        recv_hold;

	telemetry_packet_framer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.s_tvalid    (s_tvalid),
		.s_tready    (s_tready),
		.s_tdata     (s_tdata),
		.m_tvalid    (m_tvalid),
		.m_tready    (m_tready),
		.m_tdata     (m_tdata),
		.m_tlast     (m_tlast),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles == CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// receiver back-pressure
	always @(negedge clk) begin
		if (recv_hold) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	// byte checker
	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_bytes.size() == 0) begin
				errors++;
				$error("unexpected frame byte: out_byte %h last_byte %b", m_tdata, m_tlast);
			end else begin
				want = pending_bytes.pop_front();
				if (m_tdata !== want.data) begin
					errors++;
					$error("out_byte: expected %h, got %h", want.data, m_tdata);
				end
				if (m_tlast !== want.last) begin
					errors++;
					$error("last_byte: expected %b, got %b", want.last, m_tlast);
				end
			end
		end
	end

	// frame for one accepted reading; advances the slot counter
	task automatic build_expected_frame(input reading_t r,
			output logic [tpf_pkg::ID_W-1:0] id, output logic [tpf_pkg::SEQ_W-1:0] seq);
		logic [tpf_pkg::HDR_W-1:0] hdr;
		logic [15:0]               crc;
		logic                      fb;
		frame_byte_t               fbyte;
		id = id_base_model + tpf_pkg::ID_W'(r.idx);
		seq = slot_seq[r.idx];
		slot_seq[r.idx] = seq + tpf_pkg::SEQ_W'(1);
		hdr = {tpf_pkg::MAGIC_WORD, tpf_pkg::VERSION_BYTE, 7'b0, r.fault, id, seq, r.ts,
			r.volt, r.curr, r.freq};
		crc = tpf_pkg::CRC_INIT;
		for (int i = tpf_pkg::HDR_W - 1; i >= 0; i--) begin
			fb = crc[15] ^ hdr[i];
			crc = {crc[14:0], 1'b0} ^ (fb ? tpf_pkg::CRC_POLY : 16'h0000);
		end
		for (int k = 0; k < tpf_pkg::CRC_SPAN; k++) begin
			fbyte.data = hdr[tpf_pkg::HDR_W - 1 - 8 * k -: 8];
			fbyte.last = 1'b0;
			pending_bytes.push_back(fbyte);
		end
		fbyte = '{crc[15:8], 1'b0};
		pending_bytes.push_back(fbyte);
		fbyte = '{crc[7:0], 1'b1};
		pending_bytes.push_back(fbyte);
	endtask

	// called and returns at a falling edge
	task automatic send_reading(input reading_t r, output logic [tpf_pkg::ID_W-1:0] id,
			output logic [tpf_pkg::SEQ_W-1:0] seq);
		if ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(negedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata <= tpf_pkg::S_TDATA_W'({r.freq, r.curr, r.volt, r.ts, r.fault, r.idx});
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		build_expected_frame(r, id, seq);
		@(negedge clk);
	endtask

	task automatic wait_frames_done();
		s_tvalid <= 1'b0;
		while (pending_bytes.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_id_base(input logic [tpf_pkg::ID_W-1:0] v);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		id_base_model = v;
	endtask

	function automatic logic [tpf_pkg::RD_W-1:0] pick_reading();
		case ($urandom_range(9))
			0: return '0;
			1: return '1;
			default: return $urandom();
		endcase
	endfunction

	function automatic reading_t random_reading();
		reading_t r;
		case ($urandom_range(9))
			0: r.idx = '0;
			1: r.idx = '1;
			2, 3, 4, 5: r.idx = tpf_pkg::IDX_W'($urandom_range(7));
			default: r.idx = tpf_pkg::IDX_W'($urandom_range(tpf_pkg::MAX_SENSORS_DEF - 1));
		endcase
		r.fault = 1'($urandom_range(1));
		case ($urandom_range(9))
			0: r.ts = '0;
			1: r.ts = '1;
			default: r.ts = {$urandom(), $urandom()};
		endcase
		r.volt = pick_reading();
		r.curr = pick_reading();
		r.freq = pick_reading();
		return r;
	endfunction

	task automatic run_random(input int unsigned count);
		logic [tpf_pkg::ID_W-1:0]  id;
		logic [tpf_pkg::SEQ_W-1:0] seq;
		repeat (count) send_reading(random_reading(), id, seq);
	endtask

	initial begin
		logic [tpf_pkg::ID_W-1:0]  id;
		logic [tpf_pkg::SEQ_W-1:0] seq;
		int unsigned               idle_set [4];
		int unsigned               stall_set [4];
		logic [tpf_pkg::ID_W-1:0]  base_set [4];

		clk = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		recv_hold = 1'b0;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		cycles = 0;
		errors = 0;
		id_base_model = tpf_pkg::ID_BASE_RST;
		foreach (slot_seq[i]) slot_seq[i] = '0;

		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed table, no idling
		for (int i = 0; i < N_DIR; i++) begin
			if (DIR_ROWS[i].wr_cfg) begin
				wait_frames_done();
				write_id_base(DIR_ROWS[i].cfg_val);
			end
			send_reading(DIR_ROWS[i].rd, id, seq);
			if (DIR_ROWS[i].known && id !== DIR_ROWS[i].id) begin
				errors++;
				$error("device id: expected %h, got %h", DIR_ROWS[i].id, id);
			end
			if (DIR_ROWS[i].known && seq !== DIR_ROWS[i].seq) begin
				errors++;
				$error("sequence: expected %h, got %h", DIR_ROWS[i].seq, seq);
			end
		end

		// random phases: idle percentages for sender and receiver
		idle_set = '{0, 46, 0, 15};
		stall_set = '{0, 0, 46, 15};
		base_set = '{16'hFFFF, 16'h0000, 16'($urandom()), tpf_pkg::ID_BASE_RST};
		for (int p = 0; p < 4; p++) begin
			wait_frames_done();
			write_id_base(base_set[p]);
			send_idle_pct = idle_set[p];
			recv_stall_pct = stall_set[p];
			run_random(RAND_PER_PHASE);
		end

		// receiver holds off while the sender keeps offering, filling the queue
		wait_frames_done();
		write_id_base(16'($urandom()));
		send_idle_pct = 0;
		recv_stall_pct = 0;
		fork
			begin
				recv_hold = 1'b1;
				repeat (HOLD_CYCLES) @(negedge clk);
				recv_hold = 1'b0;
			end
			run_random(HOLD_ITEMS);
		join

		wait_frames_done();
		if (errors == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
